// ----- rtl/polynomial_arithmetic_engine_core_defines.svh -----
// Assertion macros for the polynomial arithmetic engine
`ifndef POLYNOMIAL_ARITHMETIC_ENGINE_CORE_DEFINES_SVH
`define POLYNOMIAL_ARITHMETIC_ENGINE_CORE_DEFINES_SVH

// implication checked on every clock edge outside reset
`define PAE_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define PAE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/pae_pkg.sv -----
// Shared constants and types for the polynomial arithmetic engine
package pae_pkg;
    localparam int MaxTerms = 64;
    localparam int ExpW = $clog2(MaxTerms);
    localparam int CoefW = 32;

    localparam logic [2:0] MODE_LOAD_ACC = 3'd0;
    localparam logic [2:0] MODE_LOAD_OPD = 3'd1;
    localparam logic [2:0] MODE_COMBINE = 3'd2;
    localparam logic [2:0] MODE_EVAL = 3'd3;
    localparam logic [2:0] MODE_READOUT = 3'd4;
    localparam logic [2:0] MODE_CLEAR = 3'd5;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;

    typedef struct packed {
        logic [2:0] mode;
        logic signed [31:0] coefficient;
        logic [5:0] exponent;
        logic signed [31:0] x_value;
    } in_beat_t;

    typedef struct packed {
        logic signed [31:0] out_coefficient;
        logic [5:0] out_exponent;
        logic signed [31:0] value;
        logic status;
        logic last;
    } out_beat_t;
endpackage

// ----- rtl/pae_stream_if.sv -----
// Valid/ready channel interface
interface pae_stream_if #(parameter type payload_t = logic);
    logic valid;
    logic ready;
    payload_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/pae_ram.sv -----
// Generic single-port-write, single-read RAM with registered read
module pae_ram #(
    parameter int Width = 32,
    parameter int Depth = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- rtl/polynomial_arithmetic_engine_core.sv -----
// Polynomial arithmetic engine top level: acc, opd and product RAMs and a sequencer
// Term load: read, add, write back. Add/sub combine walks all terms.
// Multiply: zero the product scratch, then read, multiply and accumulate each term
// pair on one port. Evaluate: Horner, one multiply per step. Readout walks all
// entries, one result per nonzero term. After reset a clearing pass zeroes
// the acc and opd RAMs; no beat is accepted during it.
module polynomial_arithmetic_engine_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [1:0] cfg_wdata,
    pae_stream_if.sink   in_ch,
    pae_stream_if.source out_ch
);
    import pae_pkg::*;

    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE = 4'd1;
    localparam logic [3:0] ST_LD_RD = 4'd2;
    localparam logic [3:0] ST_LD_WR = 4'd3;
    localparam logic [3:0] ST_AS_RD = 4'd4;
    localparam logic [3:0] ST_AS_WR = 4'd5;
    localparam logic [3:0] ST_MU_RD = 4'd6;
    localparam logic [3:0] ST_MU_MUL = 4'd7;
    localparam logic [3:0] ST_MU_ACC = 4'd8;
    localparam logic [3:0] ST_MU_CPY = 4'd9;
    localparam logic [3:0] ST_EV_RD = 4'd10;
    localparam logic [3:0] ST_EV_ST = 4'd11;
    localparam logic [3:0] ST_RO_RD = 4'd12;
    localparam logic [3:0] ST_RO_CHK = 4'd13;
    localparam logic [3:0] ST_OUT = 4'd14;
    localparam logic [3:0] ST_OPCLR = 4'd15;

    logic [3:0] state_reg, state_next;
    logic [1:0] op_reg;
    in_beat_t item_reg;
    logic [ExpW:0] i_reg, i_next;
    logic [ExpW:0] j_reg, j_next;
    logic [CoefW-1:0] prod_reg, prod_next;
    logic [CoefW-1:0] eval_reg, eval_next;
    logic drop_reg, drop_next;
    logic [CoefW-1:0] pend_c_reg, pend_c_next;
    logic [ExpW-1:0] pend_e_reg, pend_e_next;
    logic pend_reg, pend_next;
    out_beat_t obuf_reg, obuf_next;
    logic ovalid_reg, ovalid_next;
    logic done_reg, done_next;

    // RAM ports: acc, opd, product scratch
    logic acc_we, opd_we, prd_we;
    logic [ExpW-1:0] acc_wa, opd_wa, prd_wa, acc_ra, opd_ra, prd_ra;
    logic [CoefW-1:0] acc_wd, opd_wd, prd_wd, acc_rd, opd_rd, prd_rd;

    pae_ram #(.Width(CoefW), .Depth(MaxTerms)) u_acc (
        .clk(clk), .we(acc_we), .waddr(acc_wa), .wdata(acc_wd),
        .raddr(acc_ra), .rdata(acc_rd));
    pae_ram #(.Width(CoefW), .Depth(MaxTerms)) u_opd (
        .clk(clk), .we(opd_we), .waddr(opd_wa), .wdata(opd_wd),
        .raddr(opd_ra), .rdata(opd_rd));
    pae_ram #(.Width(CoefW), .Depth(MaxTerms)) u_prd (
        .clk(clk), .we(prd_we), .waddr(prd_wa), .wdata(prd_wd),
        .raddr(prd_ra), .rdata(prd_rd));

    logic out_free;
    assign out_free = !ovalid_reg || out_ch.ready;
    assign in_ch.ready = (state_reg == ST_IDLE) && !ovalid_reg;
    assign out_ch.valid = ovalid_reg;
    assign out_ch.payload = obuf_reg;

    logic [2*ExpW:0] sum_ij;
    assign sum_ij = {{ExpW{1'b0}}, i_reg} + {{ExpW{1'b0}}, j_reg};

    always_comb
    begin
        state_next = state_reg;
        i_next = i_reg;
        j_next = j_reg;
        prod_next = prod_reg;
        eval_next = eval_reg;
        drop_next = drop_reg;
        pend_c_next = pend_c_reg;
        pend_e_next = pend_e_reg;
        pend_next = pend_reg;
        obuf_next = obuf_reg;
        ovalid_next = ovalid_reg && !out_ch.ready;
        done_next = done_reg;
        acc_we = 1'b0;
        opd_we = 1'b0;
        prd_we = 1'b0;
        acc_wa = i_reg[ExpW-1:0];
        opd_wa = i_reg[ExpW-1:0];
        prd_wa = i_reg[ExpW-1:0];
        acc_wd = '0;
        opd_wd = '0;
        prd_wd = '0;
        acc_ra = i_reg[ExpW-1:0];
        opd_ra = i_reg[ExpW-1:0];
        prd_ra = sum_ij[ExpW-1:0];
        case (state_reg)
            ST_CLEAR:
            begin
                acc_we = 1'b1;
                opd_we = 1'b1;
                i_next = i_reg + 1'b1;
                if (i_reg == (ExpW+1)'(MaxTerms - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                i_next = '0;
                j_next = '0;
                drop_next = 1'b0;
                eval_next = '0;
                if (in_ch.valid && in_ch.ready)
                begin
                    case (in_ch.payload.mode)
                        MODE_LOAD_ACC, MODE_LOAD_OPD:
                        begin
                            i_next = {1'b0, in_ch.payload.exponent};
                            state_next = ST_LD_RD;
                        end
                        MODE_COMBINE:
                            state_next = (op_reg == OP_MUL) ? ST_MU_RD :
                                         (op_reg == OP_ADD || op_reg == OP_SUB) ? ST_AS_RD
                                         : ST_OPCLR;
                        MODE_EVAL:
                        begin
                            i_next = (ExpW+1)'(MaxTerms - 1);
                            state_next = ST_EV_RD;
                        end
                        MODE_READOUT:
                        begin
                            pend_next = 1'b0;
                            state_next = ST_RO_RD;
                        end
                        MODE_CLEAR:
                            state_next = ST_CLEAR;
                        default:
                            state_next = ST_IDLE;
                    endcase
                end
            end
            ST_LD_RD:
                state_next = ST_LD_WR;
            ST_LD_WR:
            begin
                if (item_reg.mode == MODE_LOAD_ACC)
                begin
                    acc_we = 1'b1;
                    acc_wd = acc_rd + item_reg.coefficient;
                end
                else
                begin
                    opd_we = 1'b1;
                    opd_wd = opd_rd + item_reg.coefficient;
                end
                state_next = ST_IDLE;
            end
            ST_AS_RD:
                state_next = ST_AS_WR;
            ST_AS_WR:
            begin
                acc_we = 1'b1;
                acc_wd = (op_reg == OP_SUB) ? acc_rd - opd_rd : acc_rd + opd_rd;
                opd_we = 1'b1;
                i_next = i_reg + 1'b1;
                state_next = ST_AS_RD;
                if (i_reg == (ExpW+1)'(MaxTerms - 1))
                begin
                    state_next = ST_OUT;
                end
            end
            // product scratch is zeroed first; done_reg marks the zero sweep done
            ST_MU_RD:
            begin
                if (!done_reg)
                begin
                    prd_we = 1'b1;
                    prd_wa = i_reg[ExpW-1:0];
                    i_next = i_reg + 1'b1;
                    if (i_reg == (ExpW+1)'(MaxTerms - 1))
                    begin
                        done_next = 1'b1;
                        i_next = '0;
                    end
                end
                else
                begin
                    acc_ra = i_reg[ExpW-1:0];
                    opd_ra = j_reg[ExpW-1:0];
                    state_next = ST_MU_MUL;
                end
            end
            ST_MU_MUL:
            begin
                prod_next = acc_rd * opd_rd;
                if (acc_rd != '0 && opd_rd != '0 && sum_ij >= (2*ExpW+1)'(MaxTerms))
                begin
                    drop_next = 1'b1;
                end
                state_next = ST_MU_ACC;
            end
            ST_MU_ACC:
            begin
                if (sum_ij < (2*ExpW+1)'(MaxTerms))
                begin
                    prd_we = 1'b1;
                    prd_wa = sum_ij[ExpW-1:0];
                    prd_wd = prd_rd + prod_reg;
                end
                state_next = ST_MU_RD;
                if (j_reg == (ExpW+1)'(MaxTerms - 1))
                begin
                    j_next = '0;
                    i_next = i_reg + 1'b1;
                    if (i_reg == (ExpW+1)'(MaxTerms - 1))
                    begin
                        i_next = '0;
                        state_next = ST_MU_CPY;
                    end
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
            end
            ST_MU_CPY:
            begin
                // read at i; the entry read is written back in the next cycle, at i-1
                prd_ra = i_reg[ExpW-1:0];
                if (j_reg != '0)
                begin
                    acc_we = 1'b1;
                    acc_wa = ExpW'(i_reg - 1'b1);
                    acc_wd = prd_rd;
                    opd_we = 1'b1;
                    opd_wa = ExpW'(i_reg - 1'b1);
                end
                j_next = {{ExpW{1'b0}}, 1'b1};
                i_next = i_reg + 1'b1;
                if (i_reg == (ExpW+1)'(MaxTerms))
                begin
                    state_next = ST_OUT;
                end
            end
            ST_EV_RD:
                state_next = ST_EV_ST;
            ST_EV_ST:
            begin
                eval_next = eval_reg * item_reg.x_value + acc_rd;
                i_next = i_reg - 1'b1;
                state_next = ST_EV_RD;
                if (i_reg == '0)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_RO_RD:
                state_next = ST_RO_CHK;
            ST_RO_CHK:
            begin
                if (out_free)
                begin
                    if (acc_rd != '0)
                    begin
                        if (pend_reg)
                        begin
                            obuf_next = '{pend_c_reg, pend_e_reg, '0, 1'b0, 1'b0};
                            ovalid_next = 1'b1;
                        end
                        pend_next = 1'b1;
                        pend_c_next = acc_rd;
                        pend_e_next = i_reg[ExpW-1:0];
                    end
                    i_next = i_reg + 1'b1;
                    state_next = ST_RO_RD;
                    if (i_reg == (ExpW+1)'(MaxTerms - 1))
                    begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_OPCLR:
            begin
                opd_we = 1'b1;
                i_next = i_reg + 1'b1;
                if (i_reg == (ExpW+1)'(MaxTerms - 1))
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    obuf_next = '0;
                    obuf_next.last = 1'b1;
                    if (item_reg.mode == MODE_COMBINE)
                    begin
                        obuf_next.status = drop_reg && (op_reg == OP_MUL);
                    end
                    else if (item_reg.mode == MODE_EVAL)
                    begin
                        obuf_next.value = eval_reg;
                    end
                    else if (pend_reg)
                    begin
                        obuf_next.out_coefficient = pend_c_reg;
                        obuf_next.out_exponent = pend_e_reg;
                    end
                    done_next = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            op_reg <= OP_ADD;
            i_reg <= '0;
            ovalid_reg <= 1'b0;
            done_reg <= 1'b0;
            pend_reg <= 1'b0;
            drop_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg <= i_next;
            ovalid_reg <= ovalid_next;
            done_reg <= done_next;
            pend_reg <= pend_next;
            drop_reg <= drop_next;
            if (cfg_we)
            begin
                op_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            item_reg <= in_ch.payload;
        end
        j_reg <= j_next;
        prod_reg <= prod_next;
        eval_reg <= eval_next;
        pend_c_reg <= pend_c_next;
        pend_e_reg <= pend_e_next;
        obuf_reg <= obuf_next;
    end
endmodule

// ----- rtl/pae_checker.sv -----
// Port-level checker for the polynomial arithmetic engine, bound to the top level
`include "polynomial_arithmetic_engine_core_defines.svh"
module pae_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic [2:0] in_mode,
    input logic       out_valid,
    input logic       out_ready,
    input logic       out_last,
    input logic       out_status
);
    import pae_pkg::*;

    `PAE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
    `PAE_ASSERT_IMPL(a_no_accept_while_out, out_valid, !in_ready)
    // undefined modes are dropped in the accept cycle and leave the input open
    `PAE_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready && (in_mode <= MODE_CLEAR), !in_ready)
    `PAE_ASSERT_IMPL(a_status_last, out_valid && out_status, out_last)
endmodule

bind polynomial_arithmetic_engine_core pae_checker u_pae_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_mode(in_ch.payload.mode),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_last(out_ch.payload.last), .out_status(out_ch.payload.status));

// ----- sim/polynomial_arithmetic_engine_core_tb.sv -----
// Polynomial arithmetic engine testbench: directed and random beats checked by a local predictor
module polynomial_arithmetic_engine_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import pae_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_wdata = '0;

    pae_stream_if #(.payload_t(in_beat_t)) in_ch ();
    pae_stream_if #(.payload_t(out_beat_t)) out_ch ();

    polynomial_arithmetic_engine_core dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .in_ch(in_ch),
        .out_ch(out_ch)
    );

    always #1 clk = ~clk;

    // predictor state
    logic [1:0] pred_op = OP_ADD;
    logic [31:0] acc_poly [MaxTerms];
    logic [31:0] opd_poly [MaxTerms];

    in_beat_t pending_beats[$];
    out_beat_t expected_beats[$];
    int mismatches = 0;
    bit hold_long = 1'b0;

    initial begin
        in_ch.valid = 1'b0;
        in_ch.payload = '0;
        out_ch.ready = 1'b0;
        for (int i = 0; i < MaxTerms; i++)
        begin
            acc_poly[i] = '0;
            opd_poly[i] = '0;
        end
    end

    function automatic out_beat_t mk_beat(logic [31:0] c, logic [5:0] e, logic [31:0] v,
                                          logic st, logic lst);
        out_beat_t b;
        b.out_coefficient = c;
        b.out_exponent = e;
        b.value = v;
        b.status = st;
        b.last = lst;
        return b;
    endfunction

    // computes the results of one accepted beat and updates the polynomials
    task automatic predict_poly(input in_beat_t b);
        logic [31:0] prod [MaxTerms];
        logic [31:0] horner;
        logic dropped;
        int n;
        dropped = 1'b0;
        n = 0;
        case (b.mode)
            MODE_LOAD_ACC: acc_poly[b.exponent] = acc_poly[b.exponent] + b.coefficient;
            MODE_LOAD_OPD: opd_poly[b.exponent] = opd_poly[b.exponent] + b.coefficient;
            MODE_COMBINE:
            begin
                if (pred_op == OP_ADD)
                    for (int i = 0; i < MaxTerms; i++) acc_poly[i] = acc_poly[i] + opd_poly[i];
                else if (pred_op == OP_SUB)
                    for (int i = 0; i < MaxTerms; i++) acc_poly[i] = acc_poly[i] - opd_poly[i];
                else if (pred_op == OP_MUL)
                begin
                    for (int i = 0; i < MaxTerms; i++) prod[i] = '0;
                    for (int i = 0; i < MaxTerms; i++)
                        if (acc_poly[i] != 0)
                            for (int j = 0; j < MaxTerms; j++)
                                if (opd_poly[j] != 0)
                                begin
                                    if (i + j < MaxTerms)
                                        prod[i+j] = prod[i+j] + acc_poly[i] * opd_poly[j];
                                    else
                                        dropped = 1'b1;
                                end
                    for (int i = 0; i < MaxTerms; i++) acc_poly[i] = prod[i];
                end
                for (int i = 0; i < MaxTerms; i++) opd_poly[i] = '0;
                expected_beats.push_back(mk_beat('0, '0, '0, dropped, 1'b1));
            end
            MODE_EVAL:
            begin
                horner = '0;
                for (int e = MaxTerms - 1; e >= 0; e--)
                    horner = horner * b.x_value + acc_poly[e];
                expected_beats.push_back(mk_beat('0, '0, horner, 1'b0, 1'b1));
            end
            MODE_READOUT:
            begin
                for (int i = 0; i < MaxTerms; i++)
                    if (acc_poly[i] != 0)
                    begin
                        expected_beats.push_back(mk_beat(acc_poly[i], i[5:0], '0, 1'b0, 1'b0));
                        n++;
                    end
                if (n == 0)
                    expected_beats.push_back(mk_beat('0, '0, '0, 1'b0, 1'b1));
                else
                    expected_beats[expected_beats.size()-1].last = 1'b1;
            end
            MODE_CLEAR:
                for (int i = 0; i < MaxTerms; i++)
                begin
                    acc_poly[i] = '0;
                    opd_poly[i] = '0;
                end
            default: ;
        endcase
    endtask

    // driver
    int send_gap = 0;
    always @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            predict_poly(in_ch.payload);
            void'(pending_beats.pop_front());
            if (pending_beats.size() > 0 && $urandom_range(0, 3) != 0)
            begin
                in_ch.payload <= pending_beats[0];
            end
            else
            begin
                in_ch.valid <= 1'b0;
                send_gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
                                                       : $urandom_range(0, 3);
            end
        end
        else if (!in_ch.valid && rst_n)
        begin
            if (send_gap > 0)
                send_gap--;
            else if (pending_beats.size() > 0)
            begin
                in_ch.valid <= 1'b1;
                in_ch.payload <= pending_beats[0];
            end
        end
    end

    // monitor and receiver stalls
    int recv_gap = 0;
    int hold_count = 0;
    always @(posedge clk)
    begin
        if (out_ch.valid && out_ch.ready)
        begin
            if (expected_beats.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat %p", out_ch.payload);
            end
            else
            begin
                if (out_ch.payload !== expected_beats[0])
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p actual %p",
                                 expected_beats[0], out_ch.payload);
                end
                void'(expected_beats.pop_front());
            end
        end
        if (hold_long)
        begin
            hold_count++;
            out_ch.ready <= 1'b0;
            if (hold_count > 3000)
            begin
                hold_long <= 1'b0;
                hold_count = 0;
            end
        end
        else if (recv_gap > 0)
        begin
            recv_gap--;
            out_ch.ready <= 1'b0;
        end
        else if (rst_n && $urandom_range(0, 5) == 0)
        begin
            recv_gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
                                                   : $urandom_range(1, 3);
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= rst_n;
    end

    function automatic in_beat_t mk_in(logic [2:0] m, logic [31:0] c, logic [5:0] e,
                                       logic [31:0] x);
        in_beat_t b;
        b.mode = m;
        b.coefficient = c;
        b.exponent = e;
        b.x_value = x;
        return b;
    endfunction

    function automatic in_beat_t rand_in();
        int r;
        logic [31:0] c;
        r = $urandom_range(0, 99);
        c = ($urandom_range(0, 3) == 0) ? $urandom : $signed($urandom_range(0, 20)) - 10;
        if (r < 40)
            return mk_in(MODE_LOAD_ACC, c, 6'($urandom_range(0, 63)), $urandom);
        else if (r < 65)
            return mk_in(MODE_LOAD_OPD, c, 6'(($urandom_range(0, 3) == 0)
                                              ? $urandom_range(0, 63)
                                              : $urandom_range(0, 8)),
                         $urandom);
        else if (r < 75)
            return mk_in(MODE_COMBINE, $urandom, 6'($urandom), $urandom);
        else if (r < 85)
            return mk_in(MODE_EVAL, $urandom, 6'($urandom), $urandom);
        else if (r < 92)
            return mk_in(MODE_READOUT, $urandom, 6'($urandom), $urandom);
        else if (r < 96)
            return mk_in(MODE_CLEAR, $urandom, 6'($urandom), $urandom);
        else
            return mk_in(3'($urandom_range(6, 7)), $urandom, 6'($urandom), $urandom);
    endfunction

    task automatic wait_idle();
        while (pending_beats.size() > 0 || expected_beats.size() > 0 || in_ch.valid)
            @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    task automatic write_op(input logic [1:0] v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        pred_op = v;
    endtask

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        write_op(OP_ADD);
        // directed: extremes, every mode, empty readout, drop flag, odd modes
        pending_beats.push_back(mk_in(MODE_READOUT, '0, '0, '0));
        pending_beats.push_back(mk_in(MODE_EVAL, '0, '0, 32'h8000_0000));
        pending_beats.push_back(mk_in(MODE_LOAD_ACC, 32'h7fff_ffff, 6'd63, '1));
        pending_beats.push_back(mk_in(MODE_LOAD_ACC, 32'h8000_0000, 6'd0, '0));
        pending_beats.push_back(mk_in(MODE_LOAD_ACC, 32'h8000_0000, 6'd0, '0));
        pending_beats.push_back(mk_in(MODE_LOAD_OPD, 32'hffff_ffff, 6'd63, '0));
        pending_beats.push_back(mk_in(MODE_LOAD_OPD, 32'd5, 6'd1, '0));
        pending_beats.push_back(mk_in(3'd6, '1, '1, '1));
        pending_beats.push_back(mk_in(3'd7, '1, '1, '1));
        pending_beats.push_back(mk_in(MODE_COMBINE, '1, '1, '1));
        pending_beats.push_back(mk_in(MODE_READOUT, '0, '0, '0));
        pending_beats.push_back(mk_in(MODE_EVAL, '0, '0, 32'h7fff_ffff));
        pending_beats.push_back(mk_in(MODE_EVAL, '0, '0, '1));
        wait_idle();
        write_op(OP_SUB);
        pending_beats.push_back(mk_in(MODE_LOAD_OPD, 32'd3, 6'd2, '0));
        pending_beats.push_back(mk_in(MODE_COMBINE, '0, '0, '0));
        // long readout while the receiver holds off
        for (int i = 0; i < 64; i++)
            pending_beats.push_back(mk_in(MODE_LOAD_ACC, i + 1, i[5:0], '0));
        pending_beats.push_back(mk_in(MODE_READOUT, '0, '0, '0));
        pending_beats.push_back(mk_in(MODE_EVAL, '0, '0, 32'd2));
        pending_beats.push_back(mk_in(MODE_READOUT, '0, '0, '0));
        hold_long = 1'b1;
        wait_idle();
        write_op(OP_MUL);
        // drop flag with a wrapped-zero product
        pending_beats.push_back(mk_in(MODE_CLEAR, '0, '0, '0));
        pending_beats.push_back(mk_in(MODE_LOAD_ACC, 32'h0001_0000, 6'd40, '0));
        pending_beats.push_back(mk_in(MODE_LOAD_OPD, 32'h0001_0000, 6'd30, '0));
        pending_beats.push_back(mk_in(MODE_COMBINE, '0, '0, '0));
        pending_beats.push_back(mk_in(MODE_READOUT, '0, '0, '0));
        wait_idle();
        write_op(2'd3);
        pending_beats.push_back(mk_in(MODE_LOAD_ACC, 32'd9, 6'd3, '0));
        pending_beats.push_back(mk_in(MODE_LOAD_OPD, 32'd9, 6'd3, '0));
        pending_beats.push_back(mk_in(MODE_COMBINE, '0, '0, '0));
        pending_beats.push_back(mk_in(MODE_READOUT, '0, '0, '0));
        wait_idle();
        // random phases over all operations
        for (int ph = 0; ph < 4; ph++)
        begin
            write_op(ph[1:0]);
            for (int k = 0; k < 6; k++)
                pending_beats.push_back(rand_in());
            pending_beats.push_back(mk_in(MODE_READOUT, '0, '0, '0));
            wait_idle();
        end
        if (mismatches == 0 && expected_beats.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        #8ms;
        $display("TEST FAILED");
        $finish;
    end
endmodule
